>>> sv/dtpb_pkg.sv
// ----------------------------------------------------------------------------
// dtpb_pkg
// Shared types and constants of the depth to point back-projection unit.
// ----------------------------------------------------------------------------
package dtpb_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DEPTH_W    = 16;
  localparam int S_TDATA_W  = 16;
  localparam int COORD_W    = 32;
  localparam int POINT_Z_W  = 23;
  localparam int M_TDATA_W  = 88;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_FOCAL_Y  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd6;

  localparam logic [15:0] RST_CENTER_X     = 16'd6392;
  localparam logic [15:0] RST_CENTER_Y     = 16'd4810;
  localparam logic [23:0] RST_INV_FOCAL_X  = 24'd24935;
  localparam logic [23:0] RST_INV_FOCAL_Y  = 24'd24938;
  localparam logic [16:0] RST_DEPTH_LIMIT  = 17'd65536;
  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd800;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd592;

  localparam logic [DEPTH_W-1:0] INVALID_DEPTH = 16'hFFFF;

  // 1000 mm * 4096 = 125 << 15, and 65536 / 1000 = 8192 / 125
  localparam int          PROD_SHIFT = 15;
  localparam int          Z_SHIFT    = 13;
  localparam logic [7:0]  DIVISOR    = 8'd125;

  // x / 125 = (x * ceil(2^30 / 125)) >> 30, exact for x < 125 * 2^16
  localparam int          DIV_CHUNK_W = 16;
  localparam int          RECIP_SHIFT = 30;
  localparam logic [23:0] DIV_RECIP   = 24'd8589935;

  typedef struct packed {
    logic accept;
    logic mul1;
    logic mul2;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic keep;
    logic div_last;
  } dp_sts_t;

endpackage

>>> sv/depth_to_point_backprojection_unit.sv
// ----------------------------------------------------------------------------
// depth_to_point_backprojection_unit
// Pinhole back-projection of a raster depth stream to metric 3D points.
// ----------------------------------------------------------------------------
// Each depth sample is taken while the unit is idle and advances the raster
// counters. A dropped sample (invalid marker or at/above the depth limit)
// leaves the unit idle. A kept sample occupies the unit for its accept, the
// multiply steps MUL1 and MUL2, S divider steps, S being the number of
// 16-bit steps of the divide-by-125 lanes (S = 3 for the 41-bit quotient),
// and one output load. The output load waits while an earlier point is still
// undelivered. The output register holds a finished point while the next
// sample is taken.
module depth_to_point_backprojection_unit #(
  parameter int MAX_DIM = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dtpb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dtpb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [dtpb_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,  // depth_mm
  input  logic                             s_axis_tuser_i,  // frame_start
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [dtpb_pkg::M_TDATA_W-1:0]   m_axis_tdata_o   // point_x, point_y, point_z
);
  import dtpb_pkg::*;

  dp_cmd_t              cmd;
  dp_sts_t              sts;
  logic [COORD_W-1:0]   point_x, point_y;
  logic [POINT_Z_W-1:0] point_z;

  dtpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dtpb_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .depth_mm_i    (s_axis_tdata_i),
    .frame_start_i (s_axis_tuser_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .point_x_o     (point_x),
    .point_y_o     (point_y),
    .point_z_o     (point_z)
  );

  assign m_axis_tdata_o = {{(M_TDATA_W - 2*COORD_W - POINT_Z_W){1'b0}},
                           point_z, point_y, point_x};

endmodule

>>> sv/dtpb_div_lane.sv
// ----------------------------------------------------------------------------
// dtpb_div_lane
// Divider by the constant 125, sixteen quotient bits a step by reciprocal
// multiplication of the running remainder and the next dividend chunk.
// ----------------------------------------------------------------------------
module dtpb_div_lane #(
  parameter int W = 41
) (
  input  logic         clk_i,
  input  logic         load_i,
  input  logic         step_i,
  input  logic [W-1:0] dividend_i,
  output logic [W-1:0] quotient_o
);
  import dtpb_pkg::*;

  localparam int STEPS  = (W + DIV_CHUNK_W - 1) / DIV_CHUNK_W;
  localparam int SH_W   = STEPS * DIV_CHUNK_W;
  localparam int PART_W = DIV_CHUNK_W + 7;
  localparam int PROD_W = PART_W + 24;

  logic [SH_W-1:0]        dq_q, dq_d;
  logic [6:0]             rem_q, rem_d;
  logic [PART_W-1:0]      part;
  logic [PROD_W-1:0]      prod;
  logic [DIV_CHUNK_W-1:0] digit;

  always_comb begin
    part  = {rem_q, dq_q[SH_W-1 -: DIV_CHUNK_W]};
    prod  = PROD_W'(part) * PROD_W'(DIV_RECIP);
    digit = prod[RECIP_SHIFT +: DIV_CHUNK_W];
    rem_d = 7'(part - PART_W'(digit) * PART_W'(DIVISOR));
    dq_d  = {dq_q[SH_W-DIV_CHUNK_W-1:0], digit};
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      dq_q  <= SH_W'(dividend_i);
      rem_q <= '0;
    end else if (step_i) begin
      dq_q  <= dq_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = dq_q[W-1:0];

endmodule

>>> sv/dtpb_ctrl.sv
// ----------------------------------------------------------------------------
// dtpb_ctrl
// Sequencer: accept, two multiply steps, serial divide, output load.
// ----------------------------------------------------------------------------
module dtpb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  output logic              m_tvalid_o,
  input  logic              m_tready_i,
  output dtpb_pkg::dp_cmd_t cmd_o,
  input  dtpb_pkg::dp_sts_t sts_i
);
  import dtpb_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  assign slot_free  = !out_valid_q || m_tready_i;
  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = (state_q == ST_IDLE) && s_tvalid_i;
    cmd_o.mul1     = (state_q == ST_MUL1);
    cmd_o.mul2     = (state_q == ST_MUL2);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.load_out = (state_q == ST_DONE) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.accept && sts_i.keep) begin
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: state_q <= ST_MUL2;
        ST_MUL2: state_q <= ST_DIV;
        ST_DIV: begin
          if (sts_i.div_last) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_load_into_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || m_tready_i))
    else $error("result loaded over an undelivered result");

  a_div_ends_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && sts_i.div_last) |=> (state_q == ST_DONE))
    else $error("divide did not finish into output load");

  a_kept_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.accept && sts_i.keep) |=> (state_q == ST_MUL1))
    else $error("kept sample did not start the multiply");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> (out_valid_q && state_q == ST_IDLE))
    else $error("output load did not raise valid");

endmodule

>>> sv/dtpb_datapath.sv
// ----------------------------------------------------------------------------
// dtpb_datapath
// Config registers, raster counters, multipliers, divider lanes, output regs.
// ----------------------------------------------------------------------------
module dtpb_datapath #(
  parameter int MAX_DIM = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dtpb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dtpb_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [dtpb_pkg::DEPTH_W-1:0]     depth_mm_i,
  input  logic                             frame_start_i,
  input  dtpb_pkg::dp_cmd_t                cmd_i,
  output dtpb_pkg::dp_sts_t                sts_o,
  output logic [dtpb_pkg::COORD_W-1:0]     point_x_o,
  output logic [dtpb_pkg::COORD_W-1:0]     point_y_o,
  output logic [dtpb_pkg::POINT_Z_W-1:0]   point_z_o
);
  import dtpb_pkg::*;

  localparam int CW        = $clog2(MAX_DIM);
  localparam int CMP_W     = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int MAG_W     = (CW + 4 > 16) ? CW + 4 : 16;
  localparam int P1_W      = MAG_W + DEPTH_W;
  localparam int P2_W      = P1_W + 24;
  localparam int DIV_W     = P2_W - PROD_SHIFT;
  localparam int DIV_STEPS = (DIV_W + DIV_CHUNK_W - 1) / DIV_CHUNK_W;
  localparam int CNT_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  logic [15:0] cx_q, cy_q;
  logic [23:0] ifx_q, ify_q;
  logic [16:0] lim_q;
  logic [10:0] width_q, height_q;

  logic [CW-1:0] col_q, row_q, col_cur, row_cur;
  logic [CMP_W-1:0] ncol, nrow;
  logic [CW-1:0] col_d, row_d;

  logic [DEPTH_W-1:0] depth_q;
  logic [MAG_W-1:0]   mag_x_q, mag_y_q, mag_x_d, mag_y_d;
  logic               neg_x_q, neg_y_q, neg_x_d, neg_y_d;
  logic [P1_W-1:0]    p1_x_q, p1_y_q;
  logic [P2_W-1:0]    p2_x, p2_y;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIV_W-1:0]   qx, qy, qz;
  logic [DIV_W-1:0]   dvd_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= RST_CENTER_X;
      cy_q     <= RST_CENTER_Y;
      ifx_q    <= RST_INV_FOCAL_X;
      ify_q    <= RST_INV_FOCAL_Y;
      lim_q    <= RST_DEPTH_LIMIT;
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X:     cx_q     <= cfg_wdata_i[15:0];
        CFG_CENTER_Y:     cy_q     <= cfg_wdata_i[15:0];
        CFG_INV_FOCAL_X:  ifx_q    <= cfg_wdata_i;
        CFG_INV_FOCAL_Y:  ify_q    <= cfg_wdata_i;
        CFG_DEPTH_LIMIT:  lim_q    <= cfg_wdata_i[16:0];
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[10:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  function automatic logic [MAG_W:0] abs_diff(input logic [CW-1:0] pos,
                                              input logic [15:0] ctr);
    logic [MAG_W:0] p;
    logic [MAG_W:0] c;
    logic           neg;
    logic [MAG_W:0] r;
    p   = (MAG_W+1)'({pos, 4'b0000});
    c   = (MAG_W+1)'(ctr);
    neg = p < c;
    r   = neg ? (c - p) : (p - c);
    return {neg, r[MAG_W-1:0]};
  endfunction

  function automatic logic [COORD_W-1:0] sat_axis(input logic [DIV_W-1:0] q,
                                                  input logic neg);
    logic over;
    over = |q[DIV_W-1:COORD_W-1];
    if (neg) begin
      return over ? {1'b1, {(COORD_W-1){1'b0}}} : (COORD_W)'(-q[COORD_W-1:0]);
    end
    return over ? {1'b0, {(COORD_W-1){1'b1}}} : q[COORD_W-1:0];
  endfunction

  always_comb begin
    col_cur = frame_start_i ? '0 : col_q;
    row_cur = frame_start_i ? '0 : row_q;
    {neg_x_d, mag_x_d} = abs_diff(col_cur, cx_q);
    {neg_y_d, mag_y_d} = abs_diff(row_cur, cy_q);

    ncol  = CMP_W'(col_cur) + CMP_W'(1);
    nrow  = CMP_W'(row_cur);
    col_d = ncol[CW-1:0];
    row_d = row_cur;
    if (ncol >= CMP_W'(width_q) || ncol >= CMP_W'(MAX_DIM)) begin
      col_d = '0;
      nrow  = CMP_W'(row_cur) + CMP_W'(1);
      row_d = nrow[CW-1:0];
      if (nrow >= CMP_W'(height_q) || nrow >= CMP_W'(MAX_DIM)) begin
        row_d = '0;
      end
    end

    sts_o.keep     = (depth_mm_i != INVALID_DEPTH) && (17'(depth_mm_i) < lim_q);
    sts_o.div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (cmd_i.mul2) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  assign p2_x  = P2_W'(p1_x_q) * P2_W'(ifx_q);
  assign p2_y  = P2_W'(p1_y_q) * P2_W'(ify_q);
  assign dvd_z = DIV_W'({depth_q, {Z_SHIFT{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      depth_q <= depth_mm_i;
      mag_x_q <= mag_x_d;
      mag_y_q <= mag_y_d;
      neg_x_q <= neg_x_d;
      neg_y_q <= neg_y_d;
    end
    if (cmd_i.mul1) begin
      p1_x_q <= P1_W'(mag_x_q) * P1_W'(depth_q);
      p1_y_q <= P1_W'(mag_y_q) * P1_W'(depth_q);
    end
    if (cmd_i.load_out) begin
      point_x_o <= sat_axis(qx, neg_x_q);
      point_y_o <= sat_axis(qy, neg_y_q);
      point_z_o <= qz[POINT_Z_W-1:0];
    end
  end

  dtpb_div_lane #(.W(DIV_W)) u_div_x (
    .clk_i      (clk_i),
    .load_i     (cmd_i.mul2),
    .step_i     (cmd_i.div_step),
    .dividend_i (p2_x[P2_W-1:PROD_SHIFT]),
    .quotient_o (qx)
  );

  dtpb_div_lane #(.W(DIV_W)) u_div_y (
    .clk_i      (clk_i),
    .load_i     (cmd_i.mul2),
    .step_i     (cmd_i.div_step),
    .dividend_i (p2_y[P2_W-1:PROD_SHIFT]),
    .quotient_o (qy)
  );

  dtpb_div_lane #(.W(DIV_W)) u_div_z (
    .clk_i      (clk_i),
    .load_i     (cmd_i.mul2),
    .step_i     (cmd_i.div_step),
    .dividend_i (dvd_z),
    .quotient_o (qz)
  );

endmodule

>>> verif/depth_to_point_backprojection_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_to_point_backprojection_unit_tb
// Self-checking bench for the pinhole depth back-projection unit.
// Runs a short directed table (reset values, depth extremes, invalid marker,
// depth limit, frame start, counter wrap, saturation, unused register
// index), then randomized phases under several sender and receiver idle
// mixes. Two sweeps drive the raster counters to the dimension cap. Every
// point is checked field by field against an in-bench predictor or the table.
// ----------------------------------------------------------------------------
module depth_to_point_backprojection_unit_tb;
  import dtpb_pkg::*;

  localparam int          DIM_LIMIT      = 64;
  localparam int          SETTLE_CYCLES  = 64;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          PHASE_ITEMS    = 90;
  localparam int          SWEEP_ITEMS    = 80;
  localparam int          PLAN_LEN       = 37;
  localparam longint      MM_PER_M       = 1000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [22:0] z;
  } point_t;

  typedef enum logic {STEP_SAMPLE, STEP_CFG} step_e;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_POINT} check_e;

  typedef struct {
    step_e                 kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    logic [DEPTH_W-1:0]    depth;
    bit                    start;
    check_e                chk;
    point_t                pt;
  } step_t;

  localparam point_t NO_POINT  = '0;
  localparam point_t SAT_POINT = '{32'h8000_0000, 32'h8000_0000, 23'd4294836};
  localparam point_t AXIS_PT   = '{32'h0, 32'h0, 23'd4294836};

  logic                  clk_i;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_valid   = 1'b0;
  logic [S_TDATA_W-1:0]  s_depth   = '0;
  logic                  s_start   = 1'b0;
  logic                  m_ready   = 1'b0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [M_TDATA_W-1:0]  m_axis_tdata_o;

  depth_to_point_backprojection_unit #(
    .MAX_DIM(DIM_LIMIT)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_depth),
    .s_axis_tuser_i (s_start),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  logic [15:0]  cam_cx    = RST_CENTER_X;
  logic [15:0]  cam_cy    = RST_CENTER_Y;
  logic [23:0]  cam_ifx   = RST_INV_FOCAL_X;
  logic [23:0]  cam_ify   = RST_INV_FOCAL_Y;
  logic [16:0]  depth_lim = RST_DEPTH_LIMIT;
  logic [10:0]  img_w     = RST_IMAGE_WIDTH;
  logic [10:0]  img_h     = RST_IMAGE_HEIGHT;
  int unsigned  col_pos   = 0;
  int unsigned  row_pos   = 0;

  point_t       pending_points[$];
  int           errors        = 0;
  int unsigned  send_idle_pct = 0;
  int unsigned  stall_pct     = 0;
  int           quiet_cycles  = 0;
  step_t        plan[PLAN_LEN];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [31:0] axis_coord(input int unsigned pos, input logic [15:0] centre,
                                             input logic [23:0] inv, input logic [15:0] depth);
    logic [63:0] p;
    logic [63:0] c;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] nq;
    logic        neg;
    p   = 64'(pos) << 4;
    c   = 64'(centre);
    neg = p < c;
    mag = neg ? c - p : p - c;
    q   = mag * 64'(inv) * 64'(depth) / 64'(MM_PER_M * 4096);
    nq  = 64'd0 - q;
    if (neg) begin
      return (q >= 64'h8000_0000) ? 32'h8000_0000 : nq[31:0];
    end
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic void backproject(input logic [15:0] depth, input bit start,
                                      output bit kept, output point_t pt);
    int unsigned ncol;
    int unsigned nrow;
    logic [63:0] zq;
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    kept = (depth != INVALID_DEPTH) && ({1'b0, depth} < depth_lim);
    zq   = (64'(depth) << 16) / 64'(MM_PER_M);
    pt.x = axis_coord(col_pos, cam_cx, cam_ifx, depth);
    pt.y = axis_coord(row_pos, cam_cy, cam_ify, depth);
    pt.z = zq[22:0];
    ncol = col_pos + 1;
    nrow = row_pos;
    if (ncol >= img_w || ncol >= DIM_LIMIT) begin
      ncol = 0;
      nrow = row_pos + 1;
      if (nrow >= img_h || nrow >= DIM_LIMIT) nrow = 0;
    end
    col_pos = ncol;
    row_pos = nrow;
  endfunction

  function automatic logic [15:0] pick_depth();
    int unsigned r;
    int unsigned top;
    r = $urandom_range(99);
    if (depth_lim == 0 || r < 12) return 16'($urandom_range(65535));
    if (r < 20) return INVALID_DEPTH;
    top = (depth_lim > 17'd65535) ? 65534 : int'(depth_lim) - 1;
    if (r < 28) begin
      case ($urandom_range(4))
        0: return 16'd0;
        1: return 16'd1;
        2: return 16'd65534;
        3: return depth_lim[15:0];
        default: return 16'(top);
      endcase
    end
    return 16'($urandom_range(top, 0));
  endfunction

  function automatic logic [23:0] pick_inv();
    if ($urandom_range(3) == 0) return 24'($urandom_range(24'hFF_FFFF));
    return 24'($urandom_range(70000, 16000));
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_CENTER_X:     cam_cx    = value[15:0];
      CFG_CENTER_Y:     cam_cy    = value[15:0];
      CFG_INV_FOCAL_X:  cam_ifx   = value[23:0];
      CFG_INV_FOCAL_Y:  cam_ify   = value[23:0];
      CFG_DEPTH_LIMIT:  depth_lim = value[16:0];
      CFG_IMAGE_WIDTH:  img_w     = value[10:0];
      CFG_IMAGE_HEIGHT: img_h     = value[10:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic settle();
    s_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_camera(input logic [15:0] cx, input logic [15:0] cy,
                                input logic [23:0] ifx, input logic [23:0] ify,
                                input logic [16:0] lim, input logic [10:0] w,
                                input logic [10:0] h);
    settle();
    write_reg(CFG_CENTER_X, 24'(cx));
    write_reg(CFG_CENTER_Y, 24'(cy));
    write_reg(CFG_INV_FOCAL_X, ifx);
    write_reg(CFG_INV_FOCAL_Y, ify);
    write_reg(CFG_DEPTH_LIMIT, 24'(lim));
    write_reg(CFG_IMAGE_WIDTH, 24'(w));
    write_reg(CFG_IMAGE_HEIGHT, 24'(h));
    cfg_we <= 1'b0;
  endtask

  task automatic feed_depth(input logic [15:0] depth, input bit start, input check_e chk,
                            input point_t typed);
    point_t pt;
    bit     kept;
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_depth <= depth;
    s_start <= start;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    backproject(depth, start, kept, pt);
    if (chk == CHK_POINT) pending_points = {pending_points, typed};
    else if (chk == CHK_PREDICT && kept) pending_points = {pending_points, pt};
  endtask

  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    point_t want;
    point_t got;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got.x = m_axis_tdata_o[31:0];
      got.y = m_axis_tdata_o[63:32];
      got.z = m_axis_tdata_o[86:64];
      if (pending_points.size() == 0) begin
        errors++;
        $display("%0t: point expected none actual %h", $time, got);
      end else begin
        want = pending_points.pop_front();
        if (got.x !== want.x) begin
          errors++;
          $display("%0t: point_x expected %h actual %h", $time, want.x, got.x);
        end
        if (got.y !== want.y) begin
          errors++;
          $display("%0t: point_y expected %h actual %h", $time, want.y, got.y);
        end
        if (got.z !== want.z) begin
          errors++;
          $display("%0t: point_z expected %h actual %h", $time, want.z, got.z);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("depth_to_point_backprojection_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    bit quiet;
    bit writing;
    plan = '{
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd0, 1'b0, CHK_POINT, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'hFFFF, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd1000, 1'b0, CHK_PREDICT, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd65534, 1'b0, CHK_PREDICT, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd1, 1'b1, CHK_PREDICT, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'h5555, 1'b0, CHK_PREDICT, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'hAAAA, 1'b0, CHK_PREDICT, NO_POINT},
      '{STEP_CFG, CFG_DEPTH_LIMIT, 24'd0, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd12345, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_CFG, CFG_DEPTH_LIMIT, 24'd1000, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd999, 1'b0, CHK_PREDICT, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd1000, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_CFG, CFG_DEPTH_LIMIT, 24'd65536, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_CFG, CFG_IMAGE_WIDTH, 24'd0, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_CFG, CFG_IMAGE_HEIGHT, 24'd0, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd500, 1'b0, CHK_PREDICT, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd500, 1'b0, CHK_PREDICT, NO_POINT},
      '{STEP_CFG, CFG_IMAGE_WIDTH, 24'd3, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_CFG, CFG_IMAGE_HEIGHT, 24'd2, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd2000, 1'b1, CHK_PREDICT, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd2000, 1'b0, CHK_PREDICT, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd2000, 1'b0, CHK_PREDICT, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd2000, 1'b0, CHK_PREDICT, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd2000, 1'b0, CHK_PREDICT, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd2000, 1'b0, CHK_PREDICT, NO_POINT},
      '{STEP_CFG, CFG_UNUSED, 24'hFF_FFFF, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_CFG, CFG_CENTER_X, 24'd65535, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_CFG, CFG_CENTER_Y, 24'd65535, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_CFG, CFG_INV_FOCAL_X, 24'hFF_FFFF, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_CFG, CFG_INV_FOCAL_Y, 24'hFF_FFFF, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd65534, 1'b1, CHK_POINT, SAT_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'hFFFF, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_CFG, CFG_CENTER_X, 24'd0, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_CFG, CFG_CENTER_Y, 24'd0, 16'd0, 1'b0, CHK_NONE, NO_POINT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd65534, 1'b1, CHK_POINT, AXIS_PT},
      '{STEP_SAMPLE, CFG_CENTER_X, 24'd0, 16'd65534, 1'b0, CHK_PREDICT, NO_POINT}
    };
    quiet   = 1'b1;
    writing = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CFG) begin
        if (!quiet) settle();
        quiet   = 1'b1;
        writing = 1'b1;
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        if (writing) cfg_we <= 1'b0;
        writing = 1'b0;
        quiet   = 1'b0;
        feed_depth(plan[i].depth, plan[i].start, plan[i].chk, plan[i].pt);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: program_camera(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                          pick_inv(), pick_inv(), 17'd65536,
                          11'($urandom_range(40, 1)), 11'($urandom_range(40, 1)));
        1: program_camera(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                          24'd0, 24'hFF_FFFF, 17'd65535,
                          11'($urandom_range(40, 1)), 11'($urandom_range(40, 1)));
        2: program_camera(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                          pick_inv(), pick_inv(), 17'($urandom_range(65534, 1)),
                          11'($urandom_range(40, 1)), 11'($urandom_range(40, 1)));
        default: program_camera(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                pick_inv(), pick_inv(), 17'h1_FFFF, 11'd1024, 11'd1024);
      endcase
      send_idle_pct = (ph == 1) ? 88 : (ph == 3) ? 37 : 0;
      stall_pct     = (ph == 2) ? 88 : (ph == 3) ? 37 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == PHASE_ITEMS / 2) settle();
        feed_depth(pick_depth(), $urandom_range(19) == 0, CHK_PREDICT, NO_POINT);
      end
    end

    // Sweep the column, then the row, up to the dimension cap.
    program_camera(16'd0, 16'($urandom_range(65535)), 24'hFF_FFFF, pick_inv(),
                   17'd65536, 11'd2047, 11'd2);
    send_idle_pct = 0;
    stall_pct     = 0;
    for (int n = 0; n < SWEEP_ITEMS; n++) begin
      feed_depth(($urandom_range(31) == 0) ? 16'($urandom_range(65534, 30000)) : INVALID_DEPTH,
                 n == 0, CHK_PREDICT, NO_POINT);
    end
    program_camera(16'($urandom_range(65535)), 16'd0, pick_inv(), 24'hFF_FFFF,
                   17'd65536, 11'd0, 11'd2047);
    send_idle_pct = 37;
    stall_pct     = 37;
    for (int n = 0; n < SWEEP_ITEMS; n++) begin
      feed_depth(($urandom_range(31) == 0) ? 16'($urandom_range(65534, 30000)) : INVALID_DEPTH,
                 n == 0, CHK_PREDICT, NO_POINT);
    end

    settle();
    if (errors == 0 && pending_points.size() == 0) begin
      $display("depth_to_point_backprojection_unit_tb: clean");
    end else begin
      $display("depth_to_point_backprojection_unit_tb: errors");
    end
    $finish;
  end

endmodule
